### sv/tpfq_pkg.sv
// Shared types, codes and defaults of the transmit packet flow control queue.
`default_nettype none
package tpfq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;

	localparam logic [4:0]  MAX_QUEUE_LEN_RST  = 5'd1;
	localparam logic [15:0] MAX_PACKET_LEN_RST = 16'd1500;

	// Input word kinds.
	localparam logic [2:0] KIND_SEND     = 3'd0;
	localparam logic [2:0] KIND_SEND_CPL = 3'd1;
	localparam logic [2:0] KIND_FLOW     = 3'd2;
	localparam logic [2:0] KIND_CONTEXT  = 3'd3;
	localparam logic [2:0] KIND_SHUTDOWN = 3'd4;

	// Result word kinds.
	localparam logic [1:0] RK_STATUS   = 2'd0;
	localparam logic [1:0] RK_TRANSMIT = 2'd1;
	localparam logic [1:0] RK_RESUME   = 2'd2;
	localparam logic [1:0] RK_DISCARD  = 2'd3;

	// Send status codes.
	localparam logic [1:0] STS_CONTINUE     = 2'd0;
	localparam logic [1:0] STS_STOP         = 2'd1;
	localparam logic [1:0] STS_DISCONNECTED = 2'd2;
	localparam logic [1:0] STS_TOO_LARGE    = 2'd3;

	typedef enum logic [2:0] {
		OP_SEND,
		OP_SEND_CPL,
		OP_FLOW,
		OP_CONTEXT,
		OP_SHUTDOWN
	} op_t;

	typedef enum logic [1:0] {
		SS_IDLE,
		SS_SENDING,
		SS_SHUTDOWN
	} send_state_t;

	typedef enum logic [1:0] {
		BK_WAIT,
		BK_EXEC,
		BK_OUT
	} back_state_t;

	typedef struct packed {
		logic [4:0]  max_queue_len;
		logic [15:0] max_packet_len;
	} cfg_t;

	typedef struct packed {
		op_t         op;
		logic [15:0] tag;
		logic        flag;
		logic        too_large;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [1:0]  status;
		logic [15:0] out_tag;
		logic [4:0]  queue_count;
		logic        last;
	} res_t;

endpackage
`default_nettype wire

### sv/tpfq_if.sv
// Handshake channels for input event words and result words.
`default_nettype none
interface tpfq_evt_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [15:0] packet_tag;
	logic [15:0] packet_len;
	logic        flag_value;

	modport source (output valid, kind, packet_tag, packet_len, flag_value, input ready);
	modport sink (input valid, kind, packet_tag, packet_len, flag_value, output ready);
endinterface

interface tpfq_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic [1:0]  status;
	logic [15:0] out_tag;
	logic [4:0]  queue_count;
	logic        last;

	modport source (output valid, result_kind, status, out_tag, queue_count, last,
		input ready);
	modport sink (input valid, result_kind, status, out_tag, queue_count, last,
		output ready);
endinterface
`default_nettype wire

### sv/tx_packet_flow_control_queue_top.sv
// Transmit packet gate: send requests, link completions and flow events in, link actions out.
//
// Input words arrive on evt (valid/ready): a send request with tag and length, a link
// send-complete, a flow-control change, a context change, or entry into shutdown.
// Each word yields zero, one or two result words on res (valid/ready): send status,
// a tag to transmit, a resume indication or a discarded tag; last marks the final one.
// Two limits sit behind the APB port: the queue length at which stop is reported
// (offset 0) and the largest accepted packet length (offset 4).
// A two-entry command queue decouples input from execution, so input words are taken
// while results wait. Execution runs through a wait state and an execute state for each
// word, then presents its result words in turn; the registered read of the tag RAM
// falls in the wait state.
// The first result word is presented from the result register, which follows the command register.
// A stalled receiver holds the current result; execution waits, and input is taken
// until the command queue holds two words.
// Reset brings the link state to idle, flow control off, context active and the tag
// queue empty; both limits return to their defaults.
`default_nettype none
module tx_packet_flow_control_queue_top #(
	parameter int QUEUE_DEPTH = tpfq_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output      logic [31:0] prdata,
	output      logic        pready,
	tpfq_evt_if.sink         evt,
	tpfq_res_if.source       res
);
	tpfq_pkg::cfg_t cfg;
	tpfq_pkg::cmd_t cmd;
	logic           cmd_valid;
	logic           cmd_ready;

	tpfq_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	tpfq_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.evt      (evt),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_ready(cmd_ready)
	);

	tpfq_back #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_ready(cmd_ready),
		.res      (res)
	);
endmodule
`default_nettype wire

### sv/tpfq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tpfq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  wire logic                                         clk,
	input  wire logic                                         we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                             wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output      logic [WIDTH-1:0]                             rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

### sv/tpfq_cfg.sv
// APB register block holding the queue limit and the packet length limit.
`default_nettype none
module tpfq_cfg (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output      logic [31:0] prdata,
	output      logic        pready,
	output      tpfq_pkg::cfg_t cfg
);
	localparam logic REG_MAX_QUEUE_LEN  = 1'b0;
	localparam logic REG_MAX_PACKET_LEN = 1'b1;

	logic [4:0]  max_queue_len_q;
	logic [15:0] max_packet_len_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_queue_len_q  <= tpfq_pkg::MAX_QUEUE_LEN_RST;
			max_packet_len_q <= tpfq_pkg::MAX_PACKET_LEN_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_MAX_QUEUE_LEN:  max_queue_len_q  <= pwdata[4:0];
				REG_MAX_PACKET_LEN: max_packet_len_q <= pwdata[15:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_MAX_QUEUE_LEN:  prdata = {27'd0, max_queue_len_q};
			REG_MAX_PACKET_LEN: prdata = {16'd0, max_packet_len_q};
		endcase
	end

	assign cfg.max_queue_len  = max_queue_len_q;
	assign cfg.max_packet_len = max_packet_len_q;
endmodule
`default_nettype wire

### sv/tpfq_front.sv
// Front end: decodes input words into commands and buffers them in a two-entry queue.
`default_nettype none
module tpfq_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire tpfq_pkg::cfg_t cfg,
	tpfq_evt_if.sink            evt,
	output      logic           cmd_valid,
	output      tpfq_pkg::cmd_t cmd,
	input  wire logic           cmd_ready
);
	tpfq_pkg::cmd_t ent_q [2];
	logic           wp_q;
	logic           rp_q;
	logic [1:0]     cnt_q;
	tpfq_pkg::cmd_t dec;
	logic           keep;
	logic           push;
	logic           pop;

	always_comb begin
		dec.tag       = evt.packet_tag;
		dec.flag      = evt.flag_value;
		dec.too_large = evt.packet_len > cfg.max_packet_len;
		dec.op        = tpfq_pkg::OP_SEND;
		keep          = 1'b1;
		unique case (evt.kind)
			tpfq_pkg::KIND_SEND:     dec.op = tpfq_pkg::OP_SEND;
			tpfq_pkg::KIND_SEND_CPL: dec.op = tpfq_pkg::OP_SEND_CPL;
			tpfq_pkg::KIND_FLOW:     dec.op = tpfq_pkg::OP_FLOW;
			tpfq_pkg::KIND_CONTEXT:  dec.op = tpfq_pkg::OP_CONTEXT;
			tpfq_pkg::KIND_SHUTDOWN: dec.op = tpfq_pkg::OP_SHUTDOWN;
			default:                 keep   = 1'b0;
		endcase
	end

	// Unused kinds are taken and dropped here; they never reach the back end.
	assign evt.ready = (cnt_q != 2'd2);
	assign push      = evt.valid && evt.ready && keep;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = ent_q[rp_q];
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule
`default_nettype wire

### sv/tpfq_back.sv
// Back end: keeps the send state and tag queue, executes commands and emits result words.
`default_nettype none
module tpfq_back #(
	parameter int QUEUE_DEPTH = tpfq_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire tpfq_pkg::cfg_t cfg,
	input  wire logic           cmd_valid,
	input  wire tpfq_pkg::cmd_t cmd,
	output      logic           cmd_ready,
	tpfq_res_if.source          res
);
	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	tpfq_pkg::back_state_t bk_q, bk_d;
	tpfq_pkg::send_state_t sst_q, sst_d;
	logic                  flow_q, flow_d;
	logic                  ctx_q, ctx_d;
	logic                  fs_q, fs_d;
	logic [PTR_W-1:0]      head_q, head_d;
	logic [PTR_W-1:0]      tail_q, tail_d;
	logic [CNT_W-1:0]      cnt_q, cnt_d;
	tpfq_pkg::cmd_t        cmd_q;
	tpfq_pkg::res_t        res_q [2];
	tpfq_pkg::res_t        r0, r1, cur;
	logic                  two_q, idx_q;
	logic [1:0]            nres;
	logic                  we;
	logic [15:0]           rd_tag;
	logic                  do_drain;
	logic                  do_flush;
	logic                  full_a;
	logic                  full_b;
	logic [CMP_W-1:0]      mql_x;
	logic [CMP_W-1:0]      cnt_dx;

	tpfq_ram #(
		.WIDTH(16),
		.DEPTH(QUEUE_DEPTH)
	) u_tag_ram (
		.clk  (clk),
		.we   (we),
		.waddr(tail_q),
		.wdata(cmd_q.tag),
		.raddr(head_q),
		.rdata(rd_tag)
	);

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		ptr_next = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
	endfunction

	assign mql_x  = CMP_W'(cfg.max_queue_len);
	assign full_a = CMP_W'(cnt_q) >= mql_x;
	assign full_b = CMP_W'(cnt_d) >= mql_x;
	assign cnt_dx = CMP_W'(cnt_d);

	// Command execution: the head entry was read in the wait cycle and is valid here.
	always_comb begin
		sst_d    = sst_q;
		flow_d   = flow_q;
		ctx_d    = ctx_q;
		fs_d     = fs_q;
		head_d   = head_q;
		tail_d   = tail_q;
		cnt_d    = cnt_q;
		we       = 1'b0;
		nres     = 2'd0;
		r0       = '0;
		r1       = '0;
		do_drain = 1'b0;
		do_flush = 1'b0;
		if (bk_q == tpfq_pkg::BK_EXEC) begin
			unique case (cmd_q.op)
				tpfq_pkg::OP_SEND: begin
					if (sst_q == tpfq_pkg::SS_SHUTDOWN) begin
						r0.status = tpfq_pkg::STS_DISCONNECTED;
						nres      = 2'd1;
					end else if (cmd_q.too_large) begin
						r0.status = tpfq_pkg::STS_TOO_LARGE;
						nres      = 2'd1;
					end else if (sst_q == tpfq_pkg::SS_SENDING) begin
						if (cnt_q == CNT_FULL) begin
							r0.result_kind = tpfq_pkg::RK_DISCARD;
							r0.out_tag     = cmd_q.tag;
							nres           = 2'd2;
						end else begin
							we     = 1'b1;
							tail_d = ptr_next(tail_q);
							cnt_d  = cnt_q + CNT_W'(1);
							nres   = 2'd1;
						end
						fs_d = full_a || full_b;
						if (nres == 2'd2) begin
							r1.status = fs_d ? tpfq_pkg::STS_STOP : tpfq_pkg::STS_CONTINUE;
						end else begin
							r0.status = fs_d ? tpfq_pkg::STS_STOP : tpfq_pkg::STS_CONTINUE;
						end
					end else begin
						// Idle link: queued tags go first, the new one takes the tail.
						r0.result_kind = tpfq_pkg::RK_TRANSMIT;
						if (cnt_q != '0) begin
							r0.out_tag = rd_tag;
							we         = 1'b1;
							head_d     = ptr_next(head_q);
							tail_d     = ptr_next(tail_q);
						end else begin
							r0.out_tag = cmd_q.tag;
						end
						sst_d     = tpfq_pkg::SS_SENDING;
						fs_d      = full_a;
						r1.status = full_a ? tpfq_pkg::STS_STOP : tpfq_pkg::STS_CONTINUE;
						nres      = 2'd2;
					end
				end
				tpfq_pkg::OP_SEND_CPL: begin
					sst_d    = tpfq_pkg::SS_IDLE;
					do_drain = ctx_q && !flow_q;
				end
				tpfq_pkg::OP_FLOW: begin
					if (flow_q != cmd_q.flag) begin
						flow_d = cmd_q.flag;
						if (!cmd_q.flag) begin
							do_drain = ctx_q && (sst_q == tpfq_pkg::SS_IDLE);
						end else begin
							do_flush = 1'b1;
						end
					end
				end
				tpfq_pkg::OP_CONTEXT: begin
					if (ctx_q != cmd_q.flag) begin
						ctx_d = cmd_q.flag;
						if (cmd_q.flag) begin
							do_drain = !flow_q && (sst_q == tpfq_pkg::SS_IDLE);
						end else begin
							do_flush = 1'b1;
						end
					end
				end
				tpfq_pkg::OP_SHUTDOWN: begin
					sst_d = tpfq_pkg::SS_SHUTDOWN;
				end
				default: begin
					sst_d = sst_q;
				end
			endcase

			if (do_drain) begin
				if (cnt_q != '0) begin
					r0.result_kind = tpfq_pkg::RK_TRANSMIT;
					r0.out_tag     = rd_tag;
					nres           = 2'd1;
					head_d         = ptr_next(head_q);
					cnt_d          = cnt_q - CNT_W'(1);
					sst_d          = tpfq_pkg::SS_SENDING;
				end
				// The queue is empty after this drain when it held one tag or none.
				if (fs_q && (cnt_q <= CNT_W'(1))) begin
					if (nres == 2'd1) begin
						r1.result_kind = tpfq_pkg::RK_RESUME;
						nres           = 2'd2;
					end else begin
						r0.result_kind = tpfq_pkg::RK_RESUME;
						nres           = 2'd1;
					end
				end
			end

			if (do_flush) begin
				head_d = '0;
				tail_d = '0;
				cnt_d  = '0;
			end
		end

		r0.queue_count = cnt_dx[4:0];
		r1.queue_count = cnt_dx[4:0];
		r0.last        = (nres == 2'd1);
		r1.last        = 1'b1;
	end

	always_comb begin
		bk_d      = bk_q;
		cmd_ready = 1'b0;
		unique case (bk_q)
			tpfq_pkg::BK_WAIT: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					bk_d = tpfq_pkg::BK_EXEC;
				end
			end
			tpfq_pkg::BK_EXEC: begin
				bk_d = (nres == 2'd0) ? tpfq_pkg::BK_WAIT : tpfq_pkg::BK_OUT;
			end
			tpfq_pkg::BK_OUT: begin
				if (res.ready && (idx_q == two_q)) begin
					bk_d = tpfq_pkg::BK_WAIT;
				end
			end
			default: bk_d = tpfq_pkg::BK_WAIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bk_q <= tpfq_pkg::BK_WAIT;
		end else begin
			bk_q <= bk_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sst_q  <= tpfq_pkg::SS_IDLE;
			flow_q <= 1'b0;
			ctx_q  <= 1'b1;
			fs_q   <= 1'b0;
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
			two_q  <= 1'b0;
			idx_q  <= 1'b0;
		end else begin
			sst_q  <= sst_d;
			flow_q <= flow_d;
			ctx_q  <= ctx_d;
			fs_q   <= fs_d;
			head_q <= head_d;
			tail_q <= tail_d;
			cnt_q  <= cnt_d;
			if (bk_q == tpfq_pkg::BK_EXEC) begin
				two_q <= (nres == 2'd2);
				idx_q <= 1'b0;
			end else if (bk_q == tpfq_pkg::BK_OUT && res.ready) begin
				idx_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (bk_q == tpfq_pkg::BK_WAIT && cmd_valid) begin
			cmd_q <= cmd;
		end
		if (bk_q == tpfq_pkg::BK_EXEC) begin
			res_q[0] <= r0;
			res_q[1] <= r1;
		end
	end

	assign cur             = res_q[idx_q];
	assign res.valid       = (bk_q == tpfq_pkg::BK_OUT);
	assign res.result_kind = cur.result_kind;
	assign res.status      = cur.status;
	assign res.out_tag     = cur.out_tag;
	assign res.queue_count = cur.queue_count;
	assign res.last        = cur.last;
endmodule
`default_nettype wire

### tb/testbench.sv
// Testbench for the transmit packet gate: a directed table, then random event words checked against a predictor.
module testbench;
	import tpfq_pkg::*;

	localparam int DEPTH = QUEUE_DEPTH_DEF;
	localparam logic [2:0] ADDR_MAX_QUEUE_LEN  = 3'd0;
	localparam logic [2:0] ADDR_MAX_PACKET_LEN = 3'd4;
	localparam int SETTLE_CYCLES = 20;
	localparam int CYCLE_LIMIT = 500000;
	localparam int NUM_SETTINGS = 8;
	localparam int ITEMS_PER_SETTING = 165;
	localparam int QUEUE_LIMITS [NUM_SETTINGS] = '{16, 1, 4, 0, 31, 8, 16, 2};
	localparam int LENGTH_LIMITS [NUM_SETTINGS] =
		'{65535, 0, 1500, 2000, 40000, 65534, 1000, 65535};

	// Burst styles of the random part.
	localparam int MODE_FLOOD    = 0;
	localparam int MODE_FILL     = 1;
	localparam int MODE_BALANCED = 2;

	typedef struct {
		logic [2:0]  kind;
		logic [15:0] tag;
		logic [15:0] len;
		logic        flag;
		int          n_fixed;
		res_t        fixed0;
		res_t        fixed1;
	} event_word_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	tpfq_evt_if evt_ch();
	tpfq_res_if res_ch();

	tx_packet_flow_control_queue_top u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.evt     (evt_ch),
		.res     (res_ch)
	);

	// Predicted state of the gate.
	send_state_t link_state;
	logic        flow_hold;
	logic        ctx_active;
	logic        stop_seen;
	logic [15:0] tag_ring [DEPTH];
	int          ring_head;
	int          ring_tail;
	logic [4:0]  queued;
	logic [4:0]  lim_queue;
	logic [15:0] lim_len;
	res_t        step_out [2];
	int          step_n;

	res_t        awaited_words [$];
	event_word_t pinned_q [$];
	event_word_t directed_rows [$];
	int          fail_count = 0;
	int          cycle_count = 0;

	always #5 clk = ~clk;

	function automatic void gate_reset();
		link_state = SS_IDLE;
		flow_hold  = 1'b0;
		ctx_active = 1'b1;
		stop_seen  = 1'b0;
		ring_head  = 0;
		ring_tail  = 0;
		queued     = '0;
		lim_queue  = MAX_QUEUE_LEN_RST;
		lim_len    = MAX_PACKET_LEN_RST;
	endfunction

	function automatic void emit_word(logic [1:0] rk, logic [1:0] st, logic [15:0] tag);
		step_out[step_n].result_kind = rk;
		step_out[step_n].status      = st;
		step_out[step_n].out_tag     = tag;
		step_out[step_n].queue_count = '0;
		step_out[step_n].last        = 1'b0;
		step_n++;
	endfunction

	function automatic void ring_push(logic [15:0] tag);
		if (int'(queued) >= DEPTH) begin
			emit_word(RK_DISCARD, STS_CONTINUE, tag);
			return;
		end
		tag_ring[ring_tail] = tag;
		ring_tail = (ring_tail + 1 >= DEPTH) ? 0 : ring_tail + 1;
		queued++;
	endfunction

	function automatic logic [15:0] ring_pop();
		logic [15:0] t;
		t = tag_ring[ring_head];
		ring_head = (ring_head + 1 >= DEPTH) ? 0 : ring_head + 1;
		queued--;
		return t;
	endfunction

	function automatic void flush_ring();
		ring_head = 0;
		ring_tail = 0;
		queued = '0;
	endfunction

	// Every status decision refreshes the sticky stop flag.
	function automatic logic [1:0] stop_check();
		stop_seen = (queued >= lim_queue);
		return stop_seen ? STS_STOP : STS_CONTINUE;
	endfunction

	function automatic logic tx_allowed();
		return ctx_active && !flow_hold;
	endfunction

	function automatic void drain_link();
		if (link_state != SS_IDLE)
			return;
		if (queued != 0) begin
			emit_word(RK_TRANSMIT, STS_CONTINUE, ring_pop());
			link_state = SS_SENDING;
		end
		if (stop_seen && queued == 0)
			emit_word(RK_RESUME, STS_CONTINUE, 16'h0000);
	endfunction

	function automatic void predict_gate_results(logic [2:0] kind, logic [15:0] tag,
			logic [15:0] len, logic flag);
		step_n = 0;
		case (kind)
			KIND_SEND: begin
				if (link_state == SS_SHUTDOWN) begin
					emit_word(RK_STATUS, STS_DISCONNECTED, 16'h0000);
				end else if (len > lim_len) begin
					emit_word(RK_STATUS, STS_TOO_LARGE, 16'h0000);
				end else if (link_state == SS_SENDING) begin
					// A discard on physical overflow comes ahead of the status word.
					ring_push(tag);
					emit_word(RK_STATUS, stop_check(), 16'h0000);
				end else begin
					// Queued tags keep their order ahead of the new one.
					if (queued != 0) begin
						emit_word(RK_TRANSMIT, STS_CONTINUE, ring_pop());
						ring_push(tag);
					end else begin
						emit_word(RK_TRANSMIT, STS_CONTINUE, tag);
					end
					link_state = SS_SENDING;
					emit_word(RK_STATUS, stop_check(), 16'h0000);
				end
			end
			KIND_SEND_CPL: begin
				link_state = SS_IDLE;
				if (tx_allowed())
					drain_link();
			end
			KIND_FLOW: begin
				if (flow_hold != flag) begin
					flow_hold = flag;
					if (!flag) begin
						if (tx_allowed())
							drain_link();
					end else begin
						flush_ring();
					end
				end
			end
			KIND_CONTEXT: begin
				if (ctx_active != flag) begin
					ctx_active = flag;
					if (flag) begin
						if (tx_allowed())
							drain_link();
					end else begin
						flush_ring();
					end
				end
			end
			KIND_SHUTDOWN: begin
				link_state = SS_SHUTDOWN;
			end
			default: begin
			end
		endcase
		for (int k = 0; k < step_n; k++) begin
			step_out[k].queue_count = queued;
			step_out[k].last = (k == step_n - 1);
		end
	endfunction

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tx_packet_flow_control_queue_top: mismatch");
			$finish;
		end
	end

	// The receiver walks through always-ready, random, and two periodic stall patterns.
	always @(posedge clk) begin
		case ((cycle_count / 700) % 4)
			0: res_ch.ready <= 1'b1;
			1: res_ch.ready <= ($urandom_range(0, 9) < 7);
			2: res_ch.ready <= ((cycle_count % 5) < 2);
			default: res_ch.ready <= ((cycle_count % 16) >= 12);
		endcase
	end

	always @(posedge clk) begin
		event_word_t w;
		res_t want;
		res_t got;
		if (arst_n && evt_ch.valid && evt_ch.ready) begin
			w = pinned_q.pop_front();
			predict_gate_results(evt_ch.kind, evt_ch.packet_tag, evt_ch.packet_len,
				evt_ch.flag_value);
			if (w.n_fixed > 0) begin
				awaited_words.push_back(w.fixed0);
				if (w.n_fixed > 1)
					awaited_words.push_back(w.fixed1);
			end else begin
				for (int k = 0; k < step_n; k++)
					awaited_words.push_back(step_out[k]);
			end
		end
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got.result_kind = res_ch.result_kind;
			got.status      = res_ch.status;
			got.out_tag     = res_ch.out_tag;
			got.queue_count = res_ch.queue_count;
			got.last        = res_ch.last;
			if (awaited_words.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result word: kind %0d status %0d tag %h count %0d last %0d",
						got.result_kind, got.status, got.out_tag, got.queue_count, got.last);
			end else begin
				want = awaited_words.pop_front();
				if (got !== want) begin
					fail_count++;
					if (fail_count <= 10)
						$display({"result word differs: expected kind %0d status %0d tag %h ",
							"count %0d last %0d, got kind %0d status %0d tag %h count %0d last %0d"},
							want.result_kind, want.status, want.out_tag, want.queue_count,
							want.last, got.result_kind, got.status, got.out_tag,
							got.queue_count, got.last);
				end
			end
		end
	end

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apb_check(input logic [2:0] addr, input logic [31:0] want);
		logic [31:0] seen;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		seen = prdata;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (seen !== want) begin
			fail_count++;
			if (fail_count <= 10)
				$display("register at %0d reads %h, expected %h", addr, seen, want);
		end
	endtask

	task automatic offer_word(input event_word_t w);
		pinned_q.push_back(w);
		evt_ch.valid      <= 1'b1;
		evt_ch.kind       <= w.kind;
		evt_ch.packet_tag <= w.tag;
		evt_ch.packet_len <= w.len;
		evt_ch.flag_value <= w.flag;
		do @(posedge clk); while (!evt_ch.ready);
	endtask

	task automatic pause_sender(input int cycles);
		evt_ch.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Holds the sender until every awaited word is back and silent words have drained.
	task automatic settle();
		evt_ch.valid <= 1'b0;
		do @(posedge clk); while (awaited_words.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic add_row(input logic [2:0] kind, input logic [15:0] tag,
			input logic [15:0] len, input logic flag, input int n, input res_t r0,
			input res_t r1);
		event_word_t w;
		w.kind = kind;
		w.tag = tag;
		w.len = len;
		w.flag = flag;
		w.n_fixed = n;
		w.fixed0 = r0;
		w.fixed1 = r1;
		directed_rows.push_back(w);
	endtask

	function automatic event_word_t random_word(input int mode);
		event_word_t w;
		int pick;
		int s_cut;
		int c_cut;
		int f_cut;
		int x_cut;
		int d_cut;
		int len_pick;
		pick = $urandom_range(0, 99);
		case (mode)
			MODE_FLOOD: begin
				s_cut = 96; c_cut = 100; f_cut = 100; x_cut = 100; d_cut = 100;
			end
			MODE_FILL: begin
				s_cut = 75; c_cut = 85; f_cut = 90; x_cut = 95; d_cut = 97;
			end
			default: begin
				s_cut = 45; c_cut = 80; f_cut = 87; x_cut = 94; d_cut = 96;
			end
		endcase
		w.n_fixed = 0;
		w.fixed0 = '0;
		w.fixed1 = '0;
		w.tag = 16'($urandom);
		w.flag = 1'($urandom);
		if (pick < s_cut) begin
			w.kind = KIND_SEND;
		end else if (pick < c_cut) begin
			w.kind = KIND_SEND_CPL;
		end else if (pick < f_cut) begin
			w.kind = KIND_FLOW;
			w.flag = ($urandom_range(0, 9) < 3);
		end else if (pick < x_cut) begin
			w.kind = KIND_CONTEXT;
			w.flag = ($urandom_range(0, 9) < 7);
		end else if (pick < d_cut) begin
			w.kind = KIND_SHUTDOWN;
		end else begin
			w.kind = KIND_SHUTDOWN + 3'($urandom_range(1, 3));
		end
		len_pick = $urandom_range(0, 9);
		if (len_pick < 6)
			w.len = 16'($urandom_range(0, int'(lim_len)));
		else if (len_pick == 6)
			w.len = lim_len;
		else if (len_pick == 7 && lim_len != 16'hFFFF)
			w.len = lim_len + 16'd1;
		else
			w.len = 16'($urandom);
		return w;
	endfunction

	initial begin
		event_word_t w;
		int issued;
		int burst;
		int gap;
		int mode;
		bit held;

		arst_n            = 1'b0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		evt_ch.valid      = 1'b0;
		evt_ch.kind       = KIND_SEND;
		evt_ch.packet_tag = '0;
		evt_ch.packet_len = '0;
		evt_ch.flag_value = 1'b0;
		res_ch.ready      = 1'b0;
		gate_reset();

		// Walk through send, queueing, drains with resume, flushes, shutdown and junk kinds.
		add_row(KIND_SEND, 16'hFFFF, 16'd1500, 1'b0, 2,
			{RK_TRANSMIT, STS_CONTINUE, 16'hFFFF, 5'd0, 1'b0},
			{RK_STATUS, STS_CONTINUE, 16'h0000, 5'd0, 1'b1});
		add_row(KIND_SEND, 16'h0000, 16'd1501, 1'b1, 1,
			{RK_STATUS, STS_TOO_LARGE, 16'h0000, 5'd0, 1'b1}, '0);
		add_row(KIND_SEND, 16'h0001, 16'd0, 1'b0, 1,
			{RK_STATUS, STS_STOP, 16'h0000, 5'd1, 1'b1}, '0);
		add_row(KIND_SEND, 16'h0002, 16'd0, 1'b1, 1,
			{RK_STATUS, STS_STOP, 16'h0000, 5'd2, 1'b1}, '0);
		add_row(KIND_SEND_CPL, 16'h0000, 16'h0000, 1'b0, 0, '0, '0);
		add_row(KIND_SEND_CPL, 16'hFFFF, 16'hFFFF, 1'b1, 0, '0, '0);
		add_row(KIND_SEND_CPL, 16'h0000, 16'h0000, 1'b0, 0, '0, '0);
		add_row(KIND_FLOW, 16'h0000, 16'h0000, 1'b1, 0, '0, '0);
		add_row(KIND_FLOW, 16'h0000, 16'h0000, 1'b1, 0, '0, '0);
		add_row(KIND_SEND, 16'hAAAA, 16'd1500, 1'b0, 0, '0, '0);
		add_row(KIND_SEND, 16'h5555, 16'd0, 1'b0, 0, '0, '0);
		add_row(KIND_CONTEXT, 16'h0000, 16'h0000, 1'b0, 0, '0, '0);
		add_row(KIND_CONTEXT, 16'h0000, 16'h0000, 1'b0, 0, '0, '0);
		add_row(KIND_CONTEXT, 16'h0000, 16'h0000, 1'b1, 0, '0, '0);
		add_row(KIND_FLOW, 16'h0000, 16'h0000, 1'b0, 0, '0, '0);
		add_row(KIND_SEND_CPL, 16'h0000, 16'h0000, 1'b0, 0, '0, '0);
		add_row(KIND_SHUTDOWN, 16'h0000, 16'h0000, 1'b0, 0, '0, '0);
		add_row(KIND_SEND, 16'h1234, 16'd10, 1'b0, 1,
			{RK_STATUS, STS_DISCONNECTED, 16'h0000, 5'd0, 1'b1}, '0);
		add_row(KIND_SHUTDOWN + 3'd1, 16'hFFFF, 16'hFFFF, 1'b1, 0, '0, '0);
		add_row(KIND_SHUTDOWN + 3'd2, 16'hFFFF, 16'hFFFF, 1'b1, 0, '0, '0);
		add_row(KIND_SHUTDOWN + 3'd3, 16'hFFFF, 16'hFFFF, 1'b1, 0, '0, '0);
		add_row(KIND_SEND_CPL, 16'h0000, 16'h0000, 1'b0, 0, '0, '0);
		add_row(KIND_SEND, 16'h7777, 16'hFFFF, 1'b0, 1,
			{RK_STATUS, STS_TOO_LARGE, 16'h0000, 5'd0, 1'b1}, '0);
		add_row(KIND_SEND, 16'h8001, 16'd0, 1'b0, 0, '0, '0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apb_check(ADDR_MAX_QUEUE_LEN, 32'(MAX_QUEUE_LEN_RST));
		apb_check(ADDR_MAX_PACKET_LEN, 32'(MAX_PACKET_LEN_RST));

		foreach (directed_rows[i]) begin
			offer_word(directed_rows[i]);
			if ($urandom_range(0, 2) == 0)
				pause_sender($urandom_range(1, 3));
		end
		settle();

		for (int s = 0; s < NUM_SETTINGS; s++) begin
			apb_write(ADDR_MAX_QUEUE_LEN, 32'(QUEUE_LIMITS[s]));
			apb_write(ADDR_MAX_PACKET_LEN, 32'(LENGTH_LIMITS[s]));
			lim_queue = 5'(QUEUE_LIMITS[s]);
			lim_len = 16'(LENGTH_LIMITS[s]);
			apb_check(ADDR_MAX_QUEUE_LEN, 32'(QUEUE_LIMITS[s]));
			apb_check(ADDR_MAX_PACKET_LEN, 32'(LENGTH_LIMITS[s]));

			issued = 0;
			held = 1'b0;
			while (issued < ITEMS_PER_SETTING) begin
				mode = $urandom_range(0, 5);
				mode = (mode == 0) ? MODE_FLOOD : (mode < 3) ? MODE_FILL : MODE_BALANCED;
				burst = $urandom_range(1, 24);
				repeat (burst) begin
					w = random_word(mode);
					offer_word(w);
					if (w.kind <= KIND_SHUTDOWN)
						issued++;
				end
				gap = $urandom_range(0, 9);
				if (!held && issued >= ITEMS_PER_SETTING / 2) begin
					settle();
					held = 1'b1;
				end else if (gap >= 8) begin
					pause_sender($urandom_range(10, 30));
				end else if (gap >= 3) begin
					pause_sender($urandom_range(1, 4));
				end
			end
			settle();
		end

		if (fail_count == 0)
			$display("tx_packet_flow_control_queue_top: match");
		else
			$display("tx_packet_flow_control_queue_top: mismatch");
		$finish;
	end

endmodule

### files.f
sv/tpfq_pkg.sv
sv/tpfq_if.sv
sv/tpfq_ram.sv
sv/tpfq_cfg.sv
sv/tpfq_front.sv
sv/tpfq_back.sv
sv/tx_packet_flow_control_queue_top.sv
tb/testbench.sv
